// ===== rtl/core/prenc_pkg.sv =====
// Shared types, constants and small arithmetic helpers for the palette residual encoder.
// Used by every module in rtl/core; has no dependencies of its own.
`default_nettype none

package prenc_pkg;

    localparam int PALETTE_BITS = 4;
    localparam int PAL_DEPTH    = 1 << PALETTE_BITS;
    localparam int CNT_W        = 5;
    localparam int STEP_W       = 8;
    localparam int CH           = 3;
    localparam int CH_W         = 8;
    localparam int DIST_W       = 20;
    localparam int Q_W          = 9;
    localparam int LAYER_W      = 7;
    localparam int LAYER_MAX    = 127;
    localparam int DIV_STEPS    = 3;
    localparam int DIV_STAGES   = Q_W / DIV_STEPS;
    localparam int TREE_MID     = PALETTE_BITS / 2;
    localparam int MID_N        = PAL_DEPTH >> TREE_MID;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 8;

    localparam logic [CFG_IDX_W-1:0] REG_PALETTE_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COARSE_STEP   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FINE_STEP     = 2'd2;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_ENCODE = 1'b1;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } rgb_t;

    typedef struct packed {
        logic                    opcode;
        logic [PALETTE_BITS-1:0] entry_index;
        logic [CH_W-1:0]         red;
        logic [CH_W-1:0]         green;
        logic [CH_W-1:0]         blue;
        logic                    last_leaf;
    } leaf_t;

    typedef struct packed {
        logic [PALETTE_BITS-1:0] token;
        logic signed [7:0]       coarse_red;
        logic signed [7:0]       coarse_green;
        logic signed [7:0]       coarse_blue;
        logic signed [7:0]       fine_red;
        logic signed [7:0]       fine_green;
        logic signed [7:0]       fine_blue;
        logic                    last_out;
    } code_t;

    // Result of the nearest-entry search, handed to the residual stages.
    typedef struct packed {
        logic                    valid;
        logic [PALETTE_BITS-1:0] token;
        rgb_t                    anchor;
        rgb_t                    target;
        logic                    last;
    } srch_t;

    typedef struct packed {
        logic                    en;
        logic [DIST_W-1:0]       score;
        logic [PALETTE_BITS-1:0] idx;
        rgb_t                    anchor;
    } node_t;

    function automatic logic [DIST_W-1:0] color_dist(input rgb_t a, input rgb_t b);
        logic signed [CH_W:0]     dr;
        logic signed [CH_W:0]     dg;
        logic signed [CH_W:0]     db;
        logic signed [2*CH_W+1:0] sr;
        logic signed [2*CH_W+1:0] sg;
        logic signed [2*CH_W+1:0] sb;
        logic [DIST_W-1:0]        r2;
        logic [DIST_W-1:0]        g2;
        logic [DIST_W-1:0]        b2;
        dr = $signed({1'b0, a.red})   - $signed({1'b0, b.red});
        dg = $signed({1'b0, a.green}) - $signed({1'b0, b.green});
        db = $signed({1'b0, a.blue})  - $signed({1'b0, b.blue});
        sr = dr * dr;
        sg = dg * dg;
        sb = db * db;
        r2 = DIST_W'($unsigned(sr));
        g2 = DIST_W'($unsigned(sg));
        b2 = DIST_W'($unsigned(sb));
        return (r2 << 1) + r2 + (g2 << 2) + (b2 << 1);
    endfunction

    // The right node wins only when strictly nearer, so ties keep the lower index.
    function automatic node_t node_merge(input node_t l, input node_t r);
        if (r.en && (r.score < l.score))
            return r;
        else
            return l;
    endfunction

    function automatic logic [LAYER_W-1:0] layer_clamp(input logic [Q_W-1:0] q);
        if (q > Q_W'(LAYER_MAX))
            return LAYER_W'(LAYER_MAX);
        else
            return q[LAYER_W-1:0];
    endfunction

    function automatic logic [7:0] apply_sign(input logic neg, input logic [LAYER_W-1:0] m);
        logic [7:0] v;
        v = {1'b0, m};
        return neg ? (8'd0 - v) : v;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/prenc_search.sv =====
// Palette store and three-stage nearest-entry search (distances, then a split compare tree).
// Depends on prenc_pkg.
`default_nettype none

module prenc_search (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              wr_en,
    input  logic [prenc_pkg::PALETTE_BITS-1:0] wr_index,
    input  logic                              enc_valid,
    input  prenc_pkg::rgb_t                   color,
    input  logic                              last,
    input  logic [prenc_pkg::CNT_W-1:0]       count,
    output prenc_pkg::srch_t                  res
);
    import prenc_pkg::*;

    rgb_t              pal_reg [PAL_DEPTH];

    logic [DIST_W-1:0] d1_reg  [PAL_DEPTH];
    rgb_t              a1_reg  [PAL_DEPTH];
    logic [PAL_DEPTH-1:0] e1_reg;
    rgb_t              t1_reg;
    logic              l1_reg;
    logic              v1_reg;

    node_t             mid_reg [MID_N];
    rgb_t              t2_reg;
    logic              l2_reg;
    logic              v2_reg;

    srch_t             res_reg;
    srch_t             res_next;

    logic [DIST_W-1:0]    d1_next [PAL_DEPTH];
    logic [PAL_DEPTH-1:0] e1_next;
    node_t                lv [PALETTE_BITS+1][PAL_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            pal_reg[wr_index] <= color;
        end
    end

    // Every entry is compared at once; entry zero always takes part.
    always_comb
    begin
        for (int i = 0; i < PAL_DEPTH; i++)
        begin
            d1_next[i] = color_dist(color, pal_reg[i]);
            e1_next[i] = (i == 0) || (i < int'(count));
        end
    end

    always_comb
    begin
        for (int l = 0; l <= PALETTE_BITS; l++)
        begin
            for (int j = 0; j < PAL_DEPTH; j++)
            begin
                lv[l][j] = '0;
            end
        end
        for (int j = 0; j < PAL_DEPTH; j++)
        begin
            lv[0][j].en     = e1_reg[j];
            lv[0][j].score  = d1_reg[j];
            lv[0][j].idx    = PALETTE_BITS'(j);
            lv[0][j].anchor = a1_reg[j];
        end
        for (int l = 1; l <= PALETTE_BITS; l++)
        begin
            for (int j = 0; j < (PAL_DEPTH >> l); j++)
            begin
                if (l - 1 == TREE_MID)
                    lv[l][j] = node_merge(mid_reg[2*j], mid_reg[2*j+1]);
                else
                    lv[l][j] = node_merge(lv[l-1][2*j], lv[l-1][2*j+1]);
            end
        end
    end

    always_comb
    begin
        res_next.valid  = v2_reg;
        res_next.token  = lv[PALETTE_BITS][0].idx;
        res_next.anchor = lv[PALETTE_BITS][0].anchor;
        res_next.target = t2_reg;
        res_next.last   = l2_reg;
        if (TREE_MID == PALETTE_BITS)
        begin
            res_next.token  = mid_reg[0].idx;
            res_next.anchor = mid_reg[0].anchor;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            res_reg.valid <= 1'b0;
        end
        else if (en)
        begin
            v1_reg  <= enc_valid;
            v2_reg  <= v1_reg;
            res_reg <= res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < PAL_DEPTH; i++)
            begin
                d1_reg[i] <= d1_next[i];
                a1_reg[i] <= pal_reg[i];
            end
            e1_reg <= e1_next;
            t1_reg <= color;
            l1_reg <= last;
            for (int j = 0; j < MID_N; j++)
            begin
                mid_reg[j] <= lv[TREE_MID][j];
            end
            t2_reg <= t1_reg;
            l2_reg <= l1_reg;
        end
    end

    assign res = res_reg;

endmodule

`default_nettype wire

// ===== rtl/core/prenc_div.sv =====
// Pipelined restoring divider for the three colour channels, a few quotient bits per stage.
// Depends on prenc_pkg; the user must hold the divisor steady while words are in flight (not enforced here).
`default_nettype none

module prenc_div (
    input  logic                          clk,
    input  logic                          en,
    input  logic [prenc_pkg::Q_W-1:0]     num [prenc_pkg::CH],
    input  logic [prenc_pkg::STEP_W-1:0]  den,
    output logic [prenc_pkg::Q_W-1:0]     quo [prenc_pkg::CH]
);
    import prenc_pkg::*;

    logic [STEP_W-1:0] rem_reg  [DIV_STAGES][CH];
    logic [Q_W-1:0]    num_reg  [DIV_STAGES][CH];
    logic [Q_W-1:0]    quo_reg  [DIV_STAGES][CH];
    logic [STEP_W-1:0] rem_next [DIV_STAGES][CH];
    logic [Q_W-1:0]    num_next [DIV_STAGES][CH];
    logic [Q_W-1:0]    quo_next [DIV_STAGES][CH];

    always_comb
    begin
        logic [STEP_W-1:0] r;
        logic [STEP_W:0]   t;
        logic [Q_W-1:0]    n;
        logic [Q_W-1:0]    q;
        int                p;
        for (int s = 0; s < DIV_STAGES; s++)
        begin
            p = (s == 0) ? 0 : s - 1;
            for (int c = 0; c < CH; c++)
            begin
                r = (s == 0) ? '0     : rem_reg[p][c];
                n = (s == 0) ? num[c] : num_reg[p][c];
                q = (s == 0) ? '0     : quo_reg[p][c];
                for (int k = 0; k < DIV_STEPS; k++)
                begin
                    t = {r, n[Q_W-1]};
                    n = n << 1;
                    if (t >= {1'b0, den})
                    begin
                        t = t - {1'b0, den};
                        q = {q[Q_W-2:0], 1'b1};
                    end
                    else
                    begin
                        q = {q[Q_W-2:0], 1'b0};
                    end
                    r = t[STEP_W-1:0];
                end
                rem_next[s][c] = r;
                num_next[s][c] = n;
                quo_next[s][c] = q;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < DIV_STAGES; s++)
            begin
                for (int c = 0; c < CH; c++)
                begin
                    rem_reg[s][c] <= rem_next[s][c];
                    num_reg[s][c] <= num_next[s][c];
                    quo_reg[s][c] <= quo_next[s][c];
                end
            end
        end
    end

    always_comb
    begin
        for (int c = 0; c < CH; c++)
        begin
            quo[c] = quo_reg[DIV_STAGES-1][c];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/palette_residual_encoder_core.sv =====
// Top level of the palette residual encoder: configuration, residual and layer stages.
// Depends on prenc_pkg, prenc_search and prenc_div.
//
//  channel   direction  handshake              payload
//  leaf      in         leaf_valid/leaf_stall  leaf (prenc_pkg::leaf_t)
//  code      out        code_valid/code_stall  code (prenc_pkg::code_t)
//  cfg       in         cfg_we                 cfg_index, cfg_data
//
// A word may enter every cycle while leaf_stall is low; an encode word passes through
// 3 search stages, 2 divider runs of 3 stages each and 4 residual stages before it leaves.
// Palette writes complete on the cycle they are taken and give no output word.
// Reset clears every valid bit and loads the register defaults; the palette is not cleared.
// The whole pipeline holds while an output word is stalled.
`default_nettype none

module palette_residual_encoder_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                leaf_valid,
    output logic                                leaf_stall,
    input  prenc_pkg::leaf_t                    leaf,
    output logic                                code_valid,
    input  logic                                code_stall,
    output prenc_pkg::code_t                    code,
    input  logic                                cfg_we,
    input  logic [prenc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [prenc_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import prenc_pkg::*;

    typedef struct packed {
        logic                         valid;
        logic [PALETTE_BITS-1:0]      token;
        logic                         last;
        logic [CH-1:0]                sign;
        logic [CH-1:0][CH_W-1:0]      mag;
    } cside_t;

    typedef struct packed {
        logic                         valid;
        logic [PALETTE_BITS-1:0]      token;
        logic                         last;
        logic [CH-1:0]                sign;
        logic [CH-1:0][CH_W-1:0]      mag;
        logic [CH-1:0][LAYER_W-1:0]   qc;
    } mside_t;

    typedef struct packed {
        logic                         valid;
        logic [PALETTE_BITS-1:0]      token;
        logic                         last;
        logic [CH-1:0][7:0]           coarse;
        logic [CH-1:0]                fsign;
    } fside_t;

    logic [CNT_W-1:0]  count_reg;
    logic [STEP_W-1:0] coarse_reg;
    logic [STEP_W-1:0] fine_reg;
    logic [STEP_W-1:0] s1_step;
    logic [STEP_W-1:0] s2_step;

    logic   en;
    logic   accept;
    srch_t  srch;

    cside_t                 s4_reg;
    cside_t                 s4_next;
    logic [Q_W-1:0]         num4_reg  [CH];
    logic [Q_W-1:0]         num4_next [CH];
    cside_t                 d1_reg    [DIV_STAGES];
    logic [Q_W-1:0]         q1        [CH];

    mside_t                 s8_reg;
    mside_t                 s8_next;
    logic [2*STEP_W-2:0]    prod8_reg  [CH];
    logic [2*STEP_W-2:0]    prod8_next [CH];

    fside_t                 s9_reg;
    fside_t                 s9_next;
    logic [Q_W-1:0]         num9_reg  [CH];
    logic [Q_W-1:0]         num9_next [CH];
    fside_t                 d2_reg    [DIV_STAGES];
    logic [Q_W-1:0]         q2        [CH];

    logic                   out_valid_reg;
    code_t                  code_reg;
    code_t                  code_next;

    assign en         = !(out_valid_reg && code_stall);
    assign leaf_stall = out_valid_reg && code_stall;
    assign accept     = leaf_valid && !leaf_stall;

    assign s1_step = (coarse_reg == '0) ? STEP_W'(1) : coarse_reg;
    assign s2_step = (fine_reg == '0)   ? STEP_W'(1) : fine_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= CNT_W'(PAL_DEPTH);
            coarse_reg <= STEP_W'(16);
            fine_reg   <= STEP_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PALETTE_COUNT: count_reg  <= cfg_data[CNT_W-1:0];
                REG_COARSE_STEP:   coarse_reg <= cfg_data[STEP_W-1:0];
                REG_FINE_STEP:     fine_reg   <= cfg_data[STEP_W-1:0];
                default:           ;
            endcase
        end
    end

    prenc_search u_search (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .wr_en     (accept && (leaf.opcode == OP_WRITE)),
        .wr_index  (leaf.entry_index),
        .enc_valid (accept && (leaf.opcode == OP_ENCODE)),
        .color     ({leaf.red, leaf.green, leaf.blue}),
        .last      (leaf.last_leaf),
        .count     (count_reg),
        .res       (srch)
    );

    // Residual magnitude plus half a step, so the divider rounds half away from zero.
    always_comb
    begin
        logic signed [CH_W:0] resid;
        logic [CH_W-1:0]      t;
        logic [CH_W-1:0]      a;
        s4_next       = '0;
        s4_next.valid = srch.valid;
        s4_next.token = srch.token;
        s4_next.last  = srch.last;
        for (int c = 0; c < CH; c++)
        begin
            t = (c == 0) ? srch.target.red   : (c == 1) ? srch.target.green : srch.target.blue;
            a = (c == 0) ? srch.anchor.red   : (c == 1) ? srch.anchor.green : srch.anchor.blue;
            resid = $signed({1'b0, t}) - $signed({1'b0, a});
            s4_next.sign[c] = resid[CH_W];
            s4_next.mag[c]  = resid[CH_W] ? CH_W'(-resid) : resid[CH_W-1:0];
            num4_next[c]    = Q_W'(s4_next.mag[c]) + Q_W'(s1_step >> 1);
        end
    end

    prenc_div u_div_coarse (
        .clk (clk),
        .en  (en),
        .num (num4_reg),
        .den (s1_step),
        .quo (q1)
    );

    always_comb
    begin
        s8_next.valid = d1_reg[DIV_STAGES-1].valid;
        s8_next.token = d1_reg[DIV_STAGES-1].token;
        s8_next.last  = d1_reg[DIV_STAGES-1].last;
        s8_next.sign  = d1_reg[DIV_STAGES-1].sign;
        s8_next.mag   = d1_reg[DIV_STAGES-1].mag;
        for (int c = 0; c < CH; c++)
        begin
            s8_next.qc[c] = layer_clamp(q1[c]);
            prod8_next[c] = s8_next.qc[c] * s1_step;
        end
    end

    // What the coarse layer leaves, taken back to magnitude and sign for the fine divider.
    always_comb
    begin
        logic signed [2*STEP_W:0] diff;
        logic signed [2*STEP_W:0] rem;
        logic [CH_W-1:0]          fmag;
        s9_next       = '0;
        s9_next.valid = s8_reg.valid;
        s9_next.token = s8_reg.token;
        s9_next.last  = s8_reg.last;
        for (int c = 0; c < CH; c++)
        begin
            diff = $signed({{(STEP_W+1){1'b0}}, s8_reg.mag[c]})
                 - $signed({1'b0, 1'b0, prod8_reg[c]});
            rem  = s8_reg.sign[c] ? -diff : diff;
            s9_next.fsign[c]  = rem[2*STEP_W];
            fmag              = rem[2*STEP_W] ? CH_W'(-rem) : rem[CH_W-1:0];
            s9_next.coarse[c] = apply_sign(s8_reg.sign[c], s8_reg.qc[c]);
            num9_next[c]      = Q_W'(fmag) + Q_W'(s2_step >> 1);
        end
    end

    prenc_div u_div_fine (
        .clk (clk),
        .en  (en),
        .num (num9_reg),
        .den (s2_step),
        .quo (q2)
    );

    always_comb
    begin
        fside_t f;
        f = d2_reg[DIV_STAGES-1];
        code_next.token        = f.token;
        code_next.last_out     = f.last;
        code_next.coarse_red   = f.coarse[0];
        code_next.coarse_green = f.coarse[1];
        code_next.coarse_blue  = f.coarse[2];
        code_next.fine_red     = apply_sign(f.fsign[0], layer_clamp(q2[0]));
        code_next.fine_green   = apply_sign(f.fsign[1], layer_clamp(q2[1]));
        code_next.fine_blue    = apply_sign(f.fsign[2], layer_clamp(q2[2]));
    end

    // Only the valid bits are reset; the data fields simply follow them down the pipe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_reg.valid  <= 1'b0;
            s8_reg.valid  <= 1'b0;
            s9_reg.valid  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < DIV_STAGES; k++)
            begin
                d1_reg[k].valid <= 1'b0;
                d2_reg[k].valid <= 1'b0;
            end
        end
        else if (en)
        begin
            s4_reg    <= s4_next;
            d1_reg[0] <= s4_reg;
            d2_reg[0] <= s9_reg;
            for (int k = 1; k < DIV_STAGES; k++)
            begin
                d1_reg[k] <= d1_reg[k-1];
                d2_reg[k] <= d2_reg[k-1];
            end
            s8_reg        <= s8_next;
            s9_reg        <= s9_next;
            out_valid_reg <= d2_reg[DIV_STAGES-1].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < CH; c++)
            begin
                num4_reg[c]  <= num4_next[c];
                prod8_reg[c] <= prod8_next[c];
                num9_reg[c]  <= num9_next[c];
            end
            code_reg <= code_next;
        end
    end

    assign code_valid = out_valid_reg;
    assign code       = code_reg;

    // The token never points past the searched part of the palette.
    assert property (@(posedge clk) disable iff (!rst_n)
        (code_valid && (count_reg != '0) && (count_reg <= CNT_W'(PAL_DEPTH)))
        |-> ({1'b0, code.token} < count_reg))
        else $error("token outside searched palette range");

    // The clamp keeps both layers off the most negative byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        code_valid |-> ((code.coarse_red != -8'sd128) && (code.coarse_green != -8'sd128)
                     && (code.coarse_blue != -8'sd128) && (code.fine_red != -8'sd128)
                     && (code.fine_green != -8'sd128) && (code.fine_blue != -8'sd128)))
        else $error("layer value escaped the clamp");

    // A stalled output word stays put until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (code_valid && code_stall) |=> (code_valid && $stable(code)))
        else $error("output word changed while stalled");

    // A palette write never starts a word down the pipeline.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (leaf.opcode == OP_WRITE) && !s4_next.valid) |=> !s4_reg.valid)
        else $error("spurious word after a palette write");

endmodule

`default_nettype wire
